// ----- hdl/ppt_pkg.sv -----
// Shared types and constants for the presence peer table.
// Used by every module of the block except ppt_ram; depends on nothing.
package ppt_pkg;

    localparam int MAX_PEERS_DEF    = 16;
    localparam int PREFIX_BYTES_DEF = 8;
    localparam int KEY_MAX_W        = 64;
    localparam int SIG_W            = 8;
    localparam int COUNT_W          = 5;
    localparam int QUEUE_DEPTH      = 2;
    localparam int S_TDATA_W        = 120;
    localparam int M_TDATA_W        = 16;
    localparam int HDR_LEN          = 5;

    localparam logic [39:0] ADV_HEADER = 40'hFF_FF_46_4D_01;
    localparam logic [15:0] AGE_MAX    = 16'hFFFF;

    localparam logic signed [7:0] MIN_SIGNAL_RST = -8'sd85;
    localparam logic [63:0]       OWN_PREFIX_RST = 64'd0;
    localparam logic [15:0]       WINDOW_RST     = 16'd30000;

    typedef enum logic [2:0] {
        REQ_CLEAR     = 3'd0,
        REQ_ADVERT    = 3'd1,
        REQ_SCAN_DONE = 3'd2,
        REQ_TICK      = 3'd3,
        REQ_LOOKUP    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        OUT_NONE    = 3'd0,
        OUT_ADDED   = 3'd1,
        OUT_UPDATED = 3'd2,
        OUT_BAD     = 3'd3,
        OUT_REJECT  = 3'd4,
        OUT_FULL    = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        CFG_MIN_SIGNAL  = 2'd0,
        CFG_OWN_PREFIX  = 2'd1,
        CFG_SEEN_WINDOW = 2'd2
    } cfg_idx_t;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_ADVERT    = 3'd1,
        OP_SCAN_DONE = 3'd2,
        OP_TICK      = 3'd3,
        OP_LOOKUP    = 3'd4,
        OP_IGNORE    = 3'd5,
        OP_BAD       = 3'd6,
        OP_REJECT    = 3'd7
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [KEY_MAX_W-1:0] key;
        logic [SIG_W-1:0]     sig;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hdl/ppt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/ppt_front.sv -----
// Front end: takes input transactions and classifies them into commands.
// Depends on ppt_pkg; feeds ppt_queue.
module ppt_front import ppt_pkg::*; #(
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // payload_header[39:0], payload_length[47:40], key_prefix[111:48], signal_dbm[119:112]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]           s_tuser,
    input  logic signed [7:0]    min_signal,
    input  logic [63:0]          own_prefix,
    input  q_status_t            q_status,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam int KEY_W = 8 * PREFIX_BYTES;

    logic [39:0]       hdr;
    logic [7:0]        len;
    logic [KEY_W-1:0]  key;
    logic signed [7:0] sig;
    logic              bad_fmt;
    logic              reject;

    assign hdr = s_tdata[39:0];
    assign len = s_tdata[47:40];
    assign key = s_tdata[48 +: KEY_W];
    assign sig = $signed(s_tdata[119:112]);

    assign bad_fmt = (len != 8'(HDR_LEN + PREFIX_BYTES)) || (hdr != ADV_HEADER);
    assign reject  = (sig < min_signal) || (key == own_prefix[KEY_W-1:0]);

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid && !q_status.full;

    always_comb begin
        q_cmd.key = KEY_MAX_W'(key);
        q_cmd.sig = sig;
        unique case (req_t'(s_tuser))
            REQ_CLEAR:     q_cmd.op = OP_CLEAR;
            REQ_ADVERT: begin
                if (bad_fmt) begin
                    q_cmd.op = OP_BAD;
                end else if (reject) begin
                    q_cmd.op = OP_REJECT;
                end else begin
                    q_cmd.op = OP_ADVERT;
                end
            end
            REQ_SCAN_DONE: q_cmd.op = OP_SCAN_DONE;
            REQ_TICK:      q_cmd.op = OP_TICK;
            REQ_LOOKUP:    q_cmd.op = OP_LOOKUP;
            default:       q_cmd.op = OP_IGNORE;
        endcase
    end

endmodule

// ----- hdl/ppt_queue.sv -----
// Short command queue between front and back end.
// Depends on ppt_pkg.
module ppt_queue import ppt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/ppt_back.sv -----
// Back end: executes commands against the peer table and drives the result channel.
// Depends on ppt_pkg and ppt_ram.
module ppt_back import ppt_pkg::*; #(
    parameter int MAX_PEERS    = MAX_PEERS_DEF,
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 q_head,
    input  q_status_t            q_status,
    output logic                 q_pop,
    input  logic [15:0]          seen_window_ms,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // advert_outcome[2:0], found[3], entry_count[8:4], zero[15:9]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int KEY_W = 8 * PREFIX_BYTES;
    localparam int RW    = KEY_W + SIG_W;
    localparam int AW    = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CW    = $clog2(MAX_PEERS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;

    state_t                 state_reg,     state_next;
    cmd_t                   cmd_reg,       cmd_next;
    logic [CW-1:0]          total_reg,     total_next;
    logic                   scan_done_reg, scan_done_next;
    logic [15:0]            age_reg,       age_next;
    logic [CW-1:0]          scan_idx_reg,  scan_idx_next;
    logic [CW-1:0]          cmp_idx_reg,   cmp_idx_next;
    logic                   rd_vld_reg,    rd_vld_next;
    outcome_t               outcome_reg,   outcome_next;
    logic                   found_reg,     found_next;
    logic                   m_valid_reg,   m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg,    m_data_next;

    logic                   ram_we;
    logic                   app_we;
    logic [AW-1:0]          ram_waddr;
    logic [RW-1:0]          ram_wdata;
    logic [RW-1:0]          ram_rdata;
    logic                   issue;
    logic                   hit;
    logic signed [7:0]      stored_sig;

    ppt_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PEERS),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    assign stored_sig = $signed(ram_rdata[SIG_W-1:0]);
    assign issue      = (scan_idx_reg < total_reg);
    assign hit        = rd_vld_reg && (ram_rdata[RW-1:SIG_W] == cmd_reg.key[KEY_W-1:0]);
    assign ram_wdata  = {cmd_reg.key[KEY_W-1:0], cmd_reg.sig};

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        total_next     = total_reg;
        scan_done_next = scan_done_reg;
        age_next       = age_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_vld_next    = rd_vld_reg;
        outcome_next   = outcome_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        app_we         = 1'b0;
        ram_waddr      = cmp_idx_reg[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (!q_status.empty) begin
                    q_pop         = 1'b1;
                    cmd_next      = q_head;
                    outcome_next  = OUT_NONE;
                    found_next    = 1'b0;
                    state_next    = S_OUT;
                    scan_idx_next = '0;
                    rd_vld_next   = 1'b0;
                    unique case (q_head.op)
                        OP_CLEAR: begin
                            total_next     = '0;
                            scan_done_next = 1'b0;
                            age_next       = '0;
                        end
                        OP_SCAN_DONE: begin
                            scan_done_next = 1'b1;
                            age_next       = '0;
                        end
                        OP_TICK: begin
                            if (age_reg != AGE_MAX) begin
                                age_next = age_reg + 1'b1;
                            end
                        end
                        OP_ADVERT: state_next = S_SCAN;
                        OP_LOOKUP: begin
                            // lookups only succeed after scan end, within the window
                            if (scan_done_reg && (age_reg <= seen_window_ms)) begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_BAD:    outcome_next = OUT_BAD;
                        OP_REJECT: outcome_next = OUT_REJECT;
                        OP_IGNORE: outcome_next = OUT_NONE;
                    endcase
                end
            end
            S_SCAN: begin
                // one read issued per cycle; data compared in the cycle after
                rd_vld_next  = issue;
                cmp_idx_next = scan_idx_reg;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (hit) begin
                    state_next = S_OUT;
                    if (cmd_reg.op == OP_ADVERT) begin
                        outcome_next = OUT_UPDATED;
                        if ($signed(cmd_reg.sig) > stored_sig) begin
                            ram_we = 1'b1;
                        end
                    end else begin
                        found_next = 1'b1;
                    end
                end else if (!rd_vld_reg && !issue) begin
                    state_next = S_OUT;
                    if (cmd_reg.op == OP_ADVERT) begin
                        if (total_reg == CW'(MAX_PEERS)) begin
                            outcome_next = OUT_FULL;
                        end else begin
                            outcome_next = OUT_ADDED;
                            ram_we       = 1'b1;
                            app_we       = 1'b1;
                            ram_waddr    = total_reg[AW-1:0];
                            total_next   = total_reg + 1'b1;
                        end
                    end
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({COUNT_W'(total_reg), found_reg, outcome_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            scan_done_reg <= 1'b0;
            age_reg       <= '0;
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            scan_done_reg <= scan_done_next;
            age_reg       <= age_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            rd_vld_reg    <= rd_vld_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        outcome_reg <= outcome_next;
        found_reg   <= found_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_PEERS))
        else $error("peer count beyond table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        app_we |=> total_reg == CW'($past(total_reg) + 1'b1))
        else $error("append did not bump peer count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) && rd_vld_reg |-> cmp_idx_reg < total_reg)
        else $error("table read beyond filled entries");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == S_IDLE) && !q_status.empty)
        else $error("command taken while busy");

endmodule

// ----- hdl/presence_peer_table_unit.sv -----
// Top level of the presence peer table: configuration registers and the
// front end / queue / back end pipeline. Depends on ppt_pkg and all ppt_* modules.
// A 2-entry command queue lets input be taken while the back end works. Reset clears
// control state and loads configuration defaults; table contents are undefined until
// written and no clearing pass is needed.
module presence_peer_table_unit import ppt_pkg::*; #(
    parameter int MAX_PEERS    = MAX_PEERS_DEF,
    parameter int PREFIX_BYTES = PREFIX_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // payload_header[39:0], payload_length[47:40], key_prefix[111:48], signal_dbm[119:112]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[2:0]
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // advert_outcome[2:0], found[3], entry_count[8:4], zero[15:9]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_wdata
);

    logic signed [7:0] min_signal_reg;
    logic [63:0]       own_prefix_reg;
    logic [15:0]       window_reg;

    logic      q_push;
    logic      q_pop;
    cmd_t      q_cmd;
    cmd_t      q_head;
    q_status_t q_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_signal_reg <= MIN_SIGNAL_RST;
            own_prefix_reg <= OWN_PREFIX_RST;
            window_reg     <= WINDOW_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_SIGNAL:  min_signal_reg <= $signed(cfg_wdata[7:0]);
                CFG_OWN_PREFIX:  own_prefix_reg <= cfg_wdata;
                CFG_SEEN_WINDOW: window_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    ppt_front #(
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .min_signal (min_signal_reg),
        .own_prefix (own_prefix_reg),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    ppt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    ppt_back #(
        .MAX_PEERS    (MAX_PEERS),
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_head         (q_head),
        .q_status       (q_status),
        .q_pop          (q_pop),
        .seen_window_ms (window_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule
